@@ src/ofd_pkg.sv @@
`default_nettype none
package ofd_pkg;

   localparam int HEADER_BYTES  = 20;
   localparam int TRAILER_BYTES = 2;
   localparam int COUNT_W       = 17;
   localparam int LEN_W         = COUNT_W + 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [7:0]  SOF_FIRST  = 8'h55;
   localparam logic [7:0]  SOF_SECOND = 8'hAA;
   localparam logic [15:0] CRC_POLY   = 16'h1021;

   // header byte offsets
   localparam int POS_SOF0    = 0;
   localparam int POS_SOF1    = 1;
   localparam int POS_VER     = 2;
   localparam int POS_TYPE    = 3;
   localparam int POS_FLAGS   = 4;
   localparam int POS_HLEN    = 5;
   localparam int POS_SEQ     = 6;
   localparam int POS_ACK     = 8;
   localparam int POS_CMD     = 10;
   localparam int POS_PLEN    = 12;
   localparam int POS_SESSION = 14;
   localparam int POS_HCRC    = 18;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_SIZE   = 3'd1,
      ST_FORMAT = 3'd2,
      ST_LENGTH = 3'd3,
      ST_CRC    = 3'd4
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_VERSION   = 2'd0,
      CSR_LIMIT     = 2'd1,
      CSR_CRC_INIT  = 2'd2,
      CSR_CHECK_CRC = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  protocol_version;
      logic [15:0] payload_limit;
      logic [15:0] crc_initial;
      logic        check_frame_crc;
   } csr_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      status_type  status;
      logic [7:0]  frame_type;
      logic [7:0]  frame_flags;
      logic [15:0] sequence_res;
      logic [15:0] acked_sequence;
      logic [15:0] command_id;
      logic [15:0] payload_length;
      logic [31:0] session;
   } record_type;

   // records produced by one byte, in delivery order
   typedef struct packed {
      logic [1:0] count;
      record_type first;
      record_type second;
   } push_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ src/ota_frame_deframer_core.sv @@
// Framed packet receiver. Bytes of a received buffer enter one per
// transaction on req_, the final one marked by req_end_of_buffer. Payload
// bytes (offsets 20 .. 20+payload_length-1) leave as kind 0 records on rsp_
// as they arrive; the final byte adds one kind 1 status record that carries
// the header fields when the status is ok (a final byte that is also a payload
// byte yields two records, payload first). Both CRC-16-CCITT sums (0x1021,
// MSB first) start from the crc_initial register at the start of each buffer.
// One byte is taken per cycle while req_ready is high; a byte's records are
// registered, queued behind older ones. The output queue (QUEUE_DEPTH records,
// at least 3) accepts a byte whenever it has room for two records, so a full
// payload stream runs at one byte per clock while rsp_ready stays high; a
// stalled consumer backs the queue up and drops req_ready. Registers are
// written on csr_wr_en with csr_index 0 version, 1 payload limit,
// 2 crc initial, 3 frame CRC check enable; write only between buffers.
`default_nettype none
module ota_frame_deframer_core
   import ofd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_end_of_buffer,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_record_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_frame_type,
   output logic [7:0]       rsp_frame_flags,
   output logic [15:0]      rsp_sequence_res,
   output logic [15:0]      rsp_acked_sequence,
   output logic [15:0]      rsp_command_id,
   output logic [15:0]      rsp_payload_length,
   output logic [31:0]      rsp_session,

   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   csr_type    csr_ff;
   push_type   push;
   record_type head;
   logic       accept;

   assign accept = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.protocol_version <= 8'd1;
         csr_ff.payload_limit    <= 16'd1024;
         csr_ff.crc_initial      <= 16'hFFFF;
         csr_ff.check_frame_crc  <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VERSION:   csr_ff.protocol_version <= csr_wdata[7:0];
            CSR_LIMIT:     csr_ff.payload_limit    <= csr_wdata;
            CSR_CRC_INIT:  csr_ff.crc_initial      <= csr_wdata;
            CSR_CHECK_CRC: csr_ff.check_frame_crc  <= csr_wdata[0];
         endcase
      end
   end

   // byte-by-byte framing state, CRCs and final checks
   ofd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept_i  (accept),
      .rx_byte_i (req_rx_byte),
      .last_i    (req_end_of_buffer),
      .csr_i     (csr_ff),
      .push_o    (push)
   );

   // hold records until the consumer takes them
   ofd_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .room_o  (req_ready),
      .valid_o (rsp_valid),
      .ready_i (rsp_ready),
      .head_o  (head)
   );

   assign rsp_record_kind    = head.kind;
   assign rsp_payload_byte   = head.payload_byte;
   assign rsp_status         = head.status;
   assign rsp_frame_type     = head.frame_type;
   assign rsp_frame_flags    = head.frame_flags;
   assign rsp_sequence_res   = head.sequence_res;
   assign rsp_acked_sequence = head.acked_sequence;
   assign rsp_command_id     = head.command_id;
   assign rsp_payload_length = head.payload_length;
   assign rsp_session        = head.session;

   // payload records never carry a status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_kind == KIND_PAYLOAD) |-> (rsp_status == ST_OK))
      else $error("payload record with nonzero status");

   // failed buffers expose no header fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_kind == KIND_STATUS && rsp_status != ST_OK)
         |-> (rsp_payload_length == '0 && rsp_session == '0 && rsp_command_id == '0))
      else $error("failed status record carries header fields");

   // a taken final byte always lands in the queue, so something is presented next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_buffer) |=> rsp_valid)
      else $error("final byte produced no record");

endmodule
`default_nettype wire

@@ src/ofd_parse.sv @@
`default_nettype none
module ofd_parse
   import ofd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept_i,
   input  wire logic [7:0] rx_byte_i,
   input  wire logic       last_i,
   input  wire csr_type    csr_i,
   output push_type        push_o
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        hcrc_ff, hcrc_in, hcrc_step;
   logic [15:0]        fcrc_ff, fcrc_in, fcrc_step;
   logic [7:0]         trailer_ff, trailer_in, trailer_step;
   logic [7:0]         hdr_ff [HEADER_BYTES];

   logic [15:0]        plen;
   logic [COUNT_W-1:0] trailer_pos;
   logic               past_header;
   logic               in_payload;
   logic [LEN_W-1:0]   len;
   logic [LEN_W-1:0]   len_expected;
   status_type         status;
   record_type         pay_rec;
   record_type         stat_rec;

   assign plen        = {hdr_ff[POS_PLEN+1], hdr_ff[POS_PLEN]};
   assign trailer_pos = COUNT_W'(HEADER_BYTES) + {1'b0, plen};
   assign past_header = (count_ff >= COUNT_W'(HEADER_BYTES));
   assign in_payload  = past_header && (count_ff < trailer_pos);

   // the frame CRC covers every header byte from the version on, whatever the
   // length field holds while the header is still coming in
   always_comb begin
      if (count_ff < COUNT_W'(POS_VER)) begin
         hcrc_step = csr_i.crc_initial;
         fcrc_step = csr_i.crc_initial;
      end else begin
         hcrc_step = (count_ff < COUNT_W'(POS_HCRC)) ? crc_step(hcrc_ff, rx_byte_i) : hcrc_ff;
         fcrc_step = (!past_header || count_ff < trailer_pos) ?
                     crc_step(fcrc_ff, rx_byte_i) : fcrc_ff;
      end
      trailer_step = (past_header && count_ff == trailer_pos) ? rx_byte_i : trailer_ff;
   end

   // final-byte checks, in priority order
   assign len          = {1'b0, count_ff} + LEN_W'(1);
   assign len_expected = LEN_W'(HEADER_BYTES + TRAILER_BYTES) + {2'b00, plen};

   always_comb begin
      priority if (len < LEN_W'(HEADER_BYTES + TRAILER_BYTES)) begin
         status = ST_SIZE;
      end else if (hdr_ff[POS_SOF0] != SOF_FIRST || hdr_ff[POS_SOF1] != SOF_SECOND ||
                   hdr_ff[POS_VER] != csr_i.protocol_version ||
                   hdr_ff[POS_HLEN] != 8'(HEADER_BYTES)) begin
         status = ST_FORMAT;
      end else if (plen > csr_i.payload_limit) begin
         status = ST_SIZE;
      end else if (len != len_expected) begin
         status = ST_LENGTH;
      end else if ({hdr_ff[POS_HCRC+1], hdr_ff[POS_HCRC]} != hcrc_step) begin
         status = ST_CRC;
      end else if (csr_i.check_frame_crc && ({rx_byte_i, trailer_step} != fcrc_step)) begin
         status = ST_CRC;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      pay_rec              = '0;
      pay_rec.kind         = KIND_PAYLOAD;
      pay_rec.payload_byte = rx_byte_i;
      pay_rec.status       = ST_OK;

      stat_rec        = '0;
      stat_rec.kind   = KIND_STATUS;
      stat_rec.status = status;
      if (status == ST_OK) begin
         stat_rec.frame_type     = hdr_ff[POS_TYPE];
         stat_rec.frame_flags    = hdr_ff[POS_FLAGS];
         stat_rec.sequence_res   = {hdr_ff[POS_SEQ+1], hdr_ff[POS_SEQ]};
         stat_rec.acked_sequence = {hdr_ff[POS_ACK+1], hdr_ff[POS_ACK]};
         stat_rec.command_id     = {hdr_ff[POS_CMD+1], hdr_ff[POS_CMD]};
         stat_rec.payload_length = plen;
         stat_rec.session        = {hdr_ff[POS_SESSION+3], hdr_ff[POS_SESSION+2],
                                    hdr_ff[POS_SESSION+1], hdr_ff[POS_SESSION]};
      end
   end

   always_comb begin
      push_o = '0;
      if (accept_i) begin
         if (in_payload) begin
            push_o.first  = pay_rec;
            push_o.second = stat_rec;
            push_o.count  = last_i ? 2'd2 : 2'd1;
         end else begin
            push_o.first  = stat_rec;
            push_o.second = stat_rec;
            push_o.count  = last_i ? 2'd1 : 2'd0;
         end
      end
   end

   // restart after the final byte
   always_comb begin
      if (last_i) begin
         count_in   = '0;
         hcrc_in    = csr_i.crc_initial;
         fcrc_in    = csr_i.crc_initial;
         trailer_in = '0;
      end else begin
         count_in   = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
         hcrc_in    = hcrc_step;
         fcrc_in    = fcrc_step;
         trailer_in = trailer_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         hcrc_ff    <= 16'hFFFF;
         fcrc_ff    <= 16'hFFFF;
         trailer_ff <= '0;
      end else if (accept_i) begin
         count_ff   <= count_in;
         hcrc_ff    <= hcrc_in;
         fcrc_ff    <= fcrc_in;
         trailer_ff <= trailer_in;
      end
   end

   for (genvar e = 0; e < HEADER_BYTES; e++) begin : g_hdr
      always_ff @(posedge clock) begin
         if (accept_i && count_ff == COUNT_W'(e)) begin
            hdr_ff[e] <= rx_byte_i;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (accept_i && !last_i) |=> (count_ff != '0))
      else $error("byte count restarted without a final byte");

   assert property (@(posedge clock) disable iff (reset)
      (push_o.count == 2'd2) |-> (push_o.first.kind == KIND_PAYLOAD &&
                                  push_o.second.kind == KIND_STATUS))
      else $error("two records from one byte not payload then status");

   assert property (@(posedge clock) disable iff (reset)
      (accept_i && last_i && len < LEN_W'(HEADER_BYTES + TRAILER_BYTES))
         |-> (status == ST_SIZE))
      else $error("short buffer not flagged");

endmodule
`default_nettype wire

@@ src/ofd_out_queue.sv @@
`default_nettype none
module ofd_out_queue
   import ofd_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push_i,
   output logic          room_o,
   output logic          valid_o,
   input  wire logic     ready_i,
   output record_type    head_o
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   record_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next1, wr_next2;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_next1 = ptr_inc(wr_ptr_ff);
   assign wr_next2 = ptr_inc(wr_next1);
   assign pop      = valid_o && ready_i;
   assign valid_o  = (count_ff != '0);
   assign room_o   = (count_ff <= CNT_W'(DEPTH - 2));
   assign head_o   = mem_ff[rd_ptr_ff];

   always_comb begin
      unique case (push_i.count)
         2'd1:    wr_ptr_in = wr_next1;
         2'd2:    wr_ptr_in = wr_next2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_i.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_i.first;
      end
      if (push_i.count == 2'd2) begin
         mem_ff[wr_next1] <= push_i.second;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("output queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      (push_i.count != 2'd0) |-> room_o)
      else $error("push without room for two records");

   assert property (@(posedge clock) disable iff (reset)
      (pop && push_i.count == 2'd0) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on pop");

endmodule
`default_nettype wire
